@@ rtl/tmw_pkg.sv @@
// Shared types and constants for the text-mode terminal writer.
// No dependencies; used by every module of the block but tmw_ram.
package tmw_pkg;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [7:0]  COLOR_RESET = 8'h07;
   localparam logic [15:0] RESET_CELL  = 16'h0720;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      OP_NOP,
      OP_PUT,
      OP_NEWLINE,
      OP_CR,
      OP_TAB,
      OP_BS,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_FILL
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] code;
      logic [6:0] col;
      logic [4:0] row;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

@@ rtl/tmw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tmw_front.sv @@
// Front end: accepts request transactions and classifies them into commands.
// Depends on tmw_pkg.
module tmw_front #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [7:0]          req_char_code,
   input  logic [6:0]          req_read_col,
   input  logic [4:0]          req_read_row,
   input  tmw_pkg::q_stat_type q_stat,
   input  logic                init_busy,
   output logic                push,
   output tmw_pkg::cmd_type    push_cmd
);

   always_comb begin
      push_cmd.code = req_char_code;
      push_cmd.col  = req_read_col;
      push_cmd.row  = req_read_row;
      push_cmd.op   = tmw_pkg::OP_NOP;
      case (req_action)
         tmw_pkg::ACT_WRITE: begin
            case (req_char_code)
               tmw_pkg::CH_NUL, tmw_pkg::CH_VT: push_cmd.op = tmw_pkg::OP_NOP;
               tmw_pkg::CH_NL:  push_cmd.op = tmw_pkg::OP_NEWLINE;
               tmw_pkg::CH_CR:  push_cmd.op = tmw_pkg::OP_CR;
               tmw_pkg::CH_TAB: push_cmd.op = tmw_pkg::OP_TAB;
               tmw_pkg::CH_BS:  push_cmd.op = tmw_pkg::OP_BS;
               default:         push_cmd.op = tmw_pkg::OP_PUT;
            endcase
         end
         tmw_pkg::ACT_READ: begin
            if ((int'(req_read_col) < COLUMNS) && (int'(req_read_row) < ROWS)) begin
               push_cmd.op = tmw_pkg::OP_READ;
            end
         end
         tmw_pkg::ACT_CLEAR: push_cmd.op = tmw_pkg::OP_CLEAR;
         default:            push_cmd.op = tmw_pkg::OP_NOP;
      endcase
   end

   assign req_ready = !q_stat.full && !init_busy;
   assign push      = req_valid && req_ready;

endmodule

@@ rtl/tmw_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on tmw_pkg.
module tmw_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tmw_pkg::cmd_type    push_cmd,
   input  logic                pop,
   output tmw_pkg::cmd_type    head_cmd,
   output tmw_pkg::q_stat_type q_stat
);

   tmw_pkg::cmd_type              slot_ff [tmw_pkg::QUEUE_DEPTH];
   logic [tmw_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tmw_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tmw_pkg::QPTR_W:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == tmw_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == tmw_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (32'(count_ff) == tmw_pkg::QUEUE_DEPTH);
   assign q_stat.empty = (count_ff == '0);

endmodule

@@ rtl/tmw_back.sv @@
// Back end: cursor, screen store, scroll/clear sweeps and result register.
// Depends on tmw_pkg and tmw_ram.
module tmw_back #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  tmw_pkg::q_stat_type q_stat,
   input  tmw_pkg::cmd_type    head_cmd,
   output logic                pop,
   input  logic [7:0]          text_color,
   output logic                init_busy,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [6:0]          rsp_cursor_col,
   output logic [4:0]          rsp_cursor_row,
   output logic [10:0]         rsp_cursor_offset,
   output logic                rsp_scrolled,
   output logic [7:0]          rsp_cell_char,
   output logic [7:0]          rsp_cell_color
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int PH_W       = $clog2(TAB_STOP);
   localparam int TGT_W      = $clog2(COLUMNS + TAB_STOP);
   localparam logic [PH_W-1:0] LAST_PHASE = PH_W'((COLUMNS - 1) % TAB_STOP);

   tmw_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [PH_W-1:0]    phase_ff, phase_in;
   logic               pend_ff, pend_in;

   logic               rsp_valid_ff;
   logic [6:0]         rsp_col_ff;
   logic [4:0]         rsp_row_ff;
   logic [10:0]        rsp_ofs_ff;
   logic               rsp_scr_ff;
   logic [7:0]         rsp_char_ff;
   logic [7:0]         rsp_color_ff;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [15:0]        wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [15:0]        rd_data;

   logic               out_free;
   logic               res_load;
   logic               res_scroll;
   logic [7:0]         res_char;
   logic [7:0]         res_color;
   logic [ADDR_W-1:0]  cur_addr;
   logic [ADDR_W-1:0]  next_addr;
   logic [TGT_W-1:0]   tab_target;

   tmw_ram #(
      .WIDTH (16),
      .DEPTH (CELL_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cur_addr   = ADDR_W'(row_ff * COLUMNS) + ADDR_W'(col_ff);
   assign tab_target = TGT_W'(col_ff) + TGT_W'(TAB_STOP) - TGT_W'(phase_ff);

   always_comb begin
      logic nl;
      nl         = 1'b0;
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      phase_in   = phase_ff;
      pend_in    = pend_ff;
      pop        = 1'b0;
      init_busy  = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = cur_addr;
      wr_data    = {text_color, head_cmd.code};
      rd_addr    = ADDR_W'(head_cmd.row * COLUMNS) + ADDR_W'(head_cmd.col);
      res_load   = 1'b0;
      res_scroll = 1'b0;
      res_char   = '0;
      res_color  = '0;
      case (state_ff)
         tmw_pkg::ST_INIT: begin
            init_busy = 1'b1;
            wr_en     = 1'b1;
            wr_addr   = cnt_ff[ADDR_W-1:0];
            wr_data   = tmw_pkg::RESET_CELL;
            if (32'(cnt_ff) == CELL_COUNT - 1) begin
               state_in = tmw_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tmw_pkg::ST_IDLE: begin
            if (!q_stat.empty && out_free) begin
               pop = 1'b1;
               case (head_cmd.op)
                  tmw_pkg::OP_CR: begin
                     col_in   = '0;
                     phase_in = '0;
                     res_load = 1'b1;
                  end
                  tmw_pkg::OP_BS: begin
                     if (col_ff == '0) begin
                        if (row_ff != '0) begin
                           col_in   = COL_W'(COLUMNS - 1);
                           row_in   = row_ff - 1'b1;
                           phase_in = LAST_PHASE;
                        end
                     end else begin
                        col_in   = col_ff - 1'b1;
                        phase_in = (phase_ff == '0) ? PH_W'(TAB_STOP - 1) : phase_ff - 1'b1;
                     end
                     res_load = 1'b1;
                  end
                  tmw_pkg::OP_NEWLINE: nl = 1'b1;
                  tmw_pkg::OP_TAB: begin
                     if (32'(tab_target) >= COLUMNS) begin
                        nl = 1'b1;
                     end else begin
                        col_in   = COL_W'(tab_target);
                        phase_in = '0;
                        res_load = 1'b1;
                     end
                  end
                  tmw_pkg::OP_PUT: begin
                     wr_en = 1'b1;
                     if (32'(col_ff) == COLUMNS - 1) begin
                        nl = 1'b1;
                     end else begin
                        col_in   = col_ff + 1'b1;
                        phase_in = (32'(phase_ff) == TAB_STOP - 1) ? '0 : phase_ff + 1'b1;
                        res_load = 1'b1;
                     end
                  end
                  tmw_pkg::OP_READ: state_in = tmw_pkg::ST_READ;
                  tmw_pkg::OP_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     phase_in = '0;
                     pend_in  = 1'b0;
                     cnt_in   = '0;
                     state_in = tmw_pkg::ST_FILL;
                  end
                  default: res_load = 1'b1;
               endcase
               if (nl) begin
                  col_in   = '0;
                  phase_in = '0;
                  if (32'(row_ff) == ROWS - 1) begin
                     pend_in  = 1'b1;
                     cnt_in   = CNT_W'(COLUMNS);
                     state_in = tmw_pkg::ST_SCROLL;
                  end else begin
                     row_in   = row_ff + 1'b1;
                     res_load = 1'b1;
                  end
               end
            end
         end
         tmw_pkg::ST_READ: begin
            res_load  = 1'b1;
            res_char  = rd_data[7:0];
            res_color = rd_data[15:8];
            state_in  = tmw_pkg::ST_IDLE;
         end
         tmw_pkg::ST_SCROLL: begin
            rd_addr = cnt_ff[ADDR_W-1:0];
            wr_addr = ADDR_W'(cnt_ff - CNT_W'(COLUMNS) - 1'b1);
            wr_data = rd_data;
            wr_en   = (32'(cnt_ff) > COLUMNS);
            if (32'(cnt_ff) == CELL_COUNT) begin
               cnt_in   = CNT_W'((ROWS - 1) * COLUMNS);
               state_in = tmw_pkg::ST_FILL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tmw_pkg::ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[ADDR_W-1:0];
            wr_data = {text_color, tmw_pkg::CH_SPACE};
            if (32'(cnt_ff) == CELL_COUNT - 1) begin
               res_load   = 1'b1;
               res_scroll = pend_ff;
               state_in   = tmw_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: state_in = tmw_pkg::ST_IDLE;
      endcase
   end

   assign next_addr = ADDR_W'(row_in * COLUMNS) + ADDR_W'(col_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmw_pkg::ST_INIT;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_col_ff   <= 7'(col_in);
         rsp_row_ff   <= 5'(row_in);
         rsp_ofs_ff   <= 11'(next_addr);
         rsp_scr_ff   <= res_scroll;
         rsp_char_ff  <= res_char;
         rsp_color_ff <= res_color;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_offset = rsp_ofs_ff;
   assign rsp_scrolled      = rsp_scr_ff;
   assign rsp_cell_char     = rsp_char_ff;
   assign rsp_cell_color    = rsp_color_ff;

endmodule

@@ rtl/text_mode_terminal_writer.sv @@
// Top level of the text-mode terminal writer: color register and wiring.
// Depends on tmw_pkg, tmw_front, tmw_queue, tmw_back (and tmw_ram below it).
//
// Usage:
//   req_*  : one transaction per byte to interpret, cell read or screen clear.
//   rsp_*  : one transaction per request, in order: cursor, offset, scroll flag
//            and, for reads, the cell contents.
//   csr_*  : writes the text color; always ready, write only while idle.
// With an idle back end, the result for a control byte or character is
// registered as its queue entry is popped; a cell read first waits in the
// read state for the registered RAM data. A clear walks every cell; a scroll
// copies the screen up one row through the screen RAM and blanks the last
// row. Throughput: one request per cycle for control bytes and characters
// while the receiver is ready and no scroll or clear is under way; a read
// holds the back end in the read state. The back end executes one command at
// a time from a two-entry queue. Reset: the screen RAM is filled with blank
// cells (space, attribute 0x07) with req_ready low; the cursor goes home.
// Receiver stall: the result stays in the output register; the queue keeps
// taking requests until it is full, then req_ready drops.
module text_mode_terminal_writer #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_char_code,
   input  logic [6:0]  req_read_col,
   input  logic [4:0]  req_read_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_cursor_col,
   output logic [4:0]  rsp_cursor_row,
   output logic [10:0] rsp_cursor_offset,
   output logic        rsp_scrolled,
   output logic [7:0]  rsp_cell_char,
   output logic [7:0]  rsp_cell_color,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic [7:0]          text_color_ff;
   tmw_pkg::q_stat_type q_stat;
   tmw_pkg::cmd_type    push_cmd;
   tmw_pkg::cmd_type    head_cmd;
   logic                push;
   logic                pop;
   logic                init_busy;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= tmw_pkg::COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         text_color_ff <= csr_data;
      end
   end

   tmw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_char_code (req_char_code),
      .req_read_col  (req_read_col),
      .req_read_row  (req_read_row),
      .q_stat        (q_stat),
      .init_busy     (init_busy),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   tmw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   tmw_back #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_stat            (q_stat),
      .head_cmd          (head_cmd),
      .pop               (pop),
      .text_color        (text_color_ff),
      .init_busy         (init_busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_offset (rsp_cursor_offset),
      .rsp_scrolled      (rsp_scrolled),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_color    (rsp_cell_color)
   );

endmodule
